// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the interlock modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interlock assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interlock assertion failed");

`endif

// ===== hdl/rfi_pkg.sv =====
package rfi_pkg;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int INH_FIELD_W = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CMD_ACTIVE_LVL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INH_CLEAR_LVL        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT_CHECK_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPTIME_CHECK_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_ENABLE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_DELAY_TICKS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS          = 3'd7;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET  = 16'd30;
    localparam logic [CFG_DATA_W-1:0] ARM_DELAY_RESET = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] PULSE_RESET     = 16'd3000;

    // Sequencer phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_FIRE = 2'd2;

    // Event codes.
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_START        = 3'd1;
    localparam logic [2:0] EV_END          = 3'd2;
    localparam logic [2:0] EV_REJ_LOCK     = 3'd3;
    localparam logic [2:0] EV_REJ_UPTIME   = 3'd4;
    localparam logic [2:0] EV_REJ_INHIBIT  = 3'd5;
    localparam logic [2:0] EV_REJ_UNSTABLE = 3'd6;

    typedef struct packed {
        logic                  cmd_active_lvl;
        logic                  inh_clear_lvl;
        logic                  inhibit_check_enable;
        logic                  uptime_check_enable;
        logic                  lockout_enable;
        logic [CFG_DATA_W-1:0] debounce_ticks;
        logic [CFG_DATA_W-1:0] arm_delay_ticks;
        logic [CFG_DATA_W-1:0] pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic                   release_level;
        logic [INH_FIELD_W-1:0] inhibit_levels;
    } in_word_t;

    typedef struct packed {
        logic       fire_enable;
        logic [1:0] phase;
        logic       locked_out;
        logic [2:0] event_res;
    } out_word_t;

endpackage

// ===== hdl/rfi_interfaces.sv =====
// Input tick word channel.
interface rfi_item_if;
    logic                            valid;
    logic                            ready;
    logic                            release_level;
    logic [rfi_pkg::INH_FIELD_W-1:0] inhibit_levels;

    modport source (output valid, output release_level, output inhibit_levels, input ready);
    modport sink (input valid, input release_level, input inhibit_levels, output ready);
endinterface

// Result word channel.
interface rfi_result_if;
    logic       valid;
    logic       ready;
    logic       fire_enable;
    logic [1:0] phase;
    logic       locked_out;
    logic [2:0] event_res;

    modport source (output valid, output fire_enable, output phase, output locked_out,
                    output event_res, input ready);
    modport sink (input valid, input fire_enable, input phase, input locked_out,
                  input event_res, output ready);
endinterface

// ===== hdl/rfi_cfg_regs.sv =====
module rfi_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rfi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfi_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output rfi_pkg::cfg_t                  cfg
);

    rfi_pkg::cfg_t cfg_reg;

    // Register file with software reset values; writes land by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_active_lvl       <= 1'b0;
            cfg_reg.inh_clear_lvl        <= 1'b1;
            cfg_reg.inhibit_check_enable <= 1'b0;
            cfg_reg.uptime_check_enable  <= 1'b0;
            cfg_reg.lockout_enable       <= 1'b0;
            cfg_reg.debounce_ticks       <= rfi_pkg::DEBOUNCE_RESET;
            cfg_reg.arm_delay_ticks      <= rfi_pkg::ARM_DELAY_RESET;
            cfg_reg.pulse_ticks          <= rfi_pkg::PULSE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rfi_pkg::REG_CMD_ACTIVE_LVL:       cfg_reg.cmd_active_lvl <= cfg_wdata[0];
                rfi_pkg::REG_INH_CLEAR_LVL:        cfg_reg.inh_clear_lvl  <= cfg_wdata[0];
                rfi_pkg::REG_INHIBIT_CHECK_ENABLE:
                    cfg_reg.inhibit_check_enable <= cfg_wdata[0];
                rfi_pkg::REG_UPTIME_CHECK_ENABLE:
                    cfg_reg.uptime_check_enable  <= cfg_wdata[0];
                rfi_pkg::REG_LOCKOUT_ENABLE:       cfg_reg.lockout_enable  <= cfg_wdata[0];
                rfi_pkg::REG_DEBOUNCE_TICKS:       cfg_reg.debounce_ticks  <= cfg_wdata;
                rfi_pkg::REG_ARM_DELAY_TICKS:      cfg_reg.arm_delay_ticks <= cfg_wdata;
                rfi_pkg::REG_PULSE_TICKS:          cfg_reg.pulse_ticks     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rfi_core.sv =====
`include "assert_macros.svh"

module rfi_core #(
    parameter int TIMER_WIDTH  = 16,
    parameter int NUM_INHIBITS = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  rfi_pkg::cfg_t      cfg,
    input  logic               step_en,
    input  rfi_pkg::in_word_t  word,
    output rfi_pkg::out_word_t res
);

    logic                    prev_active_reg;
    logic                    prev_active_next;
    logic [1:0]              phase_reg;
    logic [1:0]              phase_next;
    logic [TIMER_WIDTH-1:0]  countdown_reg;
    logic [TIMER_WIDTH-1:0]  countdown_next;
    logic [TIMER_WIDTH-1:0]  uptime_reg;
    logic [TIMER_WIDTH-1:0]  uptime_next;
    logic                    lockout_reg;
    logic                    lockout_next;

    logic                    active;
    logic                    armed;
    logic                    inh_ok;
    logic [2:0]              ev;
    logic [TIMER_WIDTH-1:0]  arm;
    logic [TIMER_WIDTH-1:0]  debounce;
    logic [TIMER_WIDTH-1:0]  pulse_raw;
    logic [TIMER_WIDTH-1:0]  pulse_load;
    logic [NUM_INHIBITS-1:0] inh_ext;
    logic [NUM_INHIBITS-1:0] inh_want;

    // Timer settings fitted to the counter width; a zero pulse acts as one tick.
    assign arm        = TIMER_WIDTH'(cfg.arm_delay_ticks);
    assign debounce   = TIMER_WIDTH'(cfg.debounce_ticks);
    assign pulse_raw  = TIMER_WIDTH'(cfg.pulse_ticks);
    assign pulse_load = (pulse_raw == '0) ? TIMER_WIDTH'(1) : pulse_raw;

    // Inhibit gate: pins above the sampled field read as zero.
    assign inh_ext  = NUM_INHIBITS'(word.inhibit_levels);
    assign inh_want = cfg.inh_clear_lvl ? '1 : '0;
    assign inh_ok   = (inh_ext == inh_want);

    assign active = (word.release_level == cfg.cmd_active_lvl);
    assign armed  = (uptime_reg >= arm);

    // Trigger, debounce and pulse sequencer.
    always_comb
    begin
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        lockout_next   = lockout_reg;
        ev             = rfi_pkg::EV_NONE;
        case (phase_reg)
            rfi_pkg::PH_IDLE:
            begin
                if (active && !prev_active_reg)
                begin
                    if (lockout_reg)
                    begin
                        ev = rfi_pkg::EV_REJ_LOCK;
                    end
                    else if (cfg.uptime_check_enable && !armed)
                    begin
                        ev = rfi_pkg::EV_REJ_UPTIME;
                    end
                    else if (cfg.inhibit_check_enable && !inh_ok)
                    begin
                        ev = rfi_pkg::EV_REJ_INHIBIT;
                    end
                    else if (debounce == '0)
                    begin
                        phase_next     = rfi_pkg::PH_FIRE;
                        countdown_next = pulse_load;
                        ev             = rfi_pkg::EV_START;
                    end
                    else
                    begin
                        phase_next     = rfi_pkg::PH_WAIT;
                        countdown_next = debounce;
                    end
                end
            end
            rfi_pkg::PH_WAIT:
            begin
                if (countdown_reg > TIMER_WIDTH'(1))
                begin
                    countdown_next = countdown_reg - TIMER_WIDTH'(1);
                end
                else if (active)
                begin
                    phase_next     = rfi_pkg::PH_FIRE;
                    countdown_next = pulse_load;
                    ev             = rfi_pkg::EV_START;
                end
                else
                begin
                    phase_next     = rfi_pkg::PH_IDLE;
                    countdown_next = '0;
                    ev             = rfi_pkg::EV_REJ_UNSTABLE;
                end
            end
            rfi_pkg::PH_FIRE:
            begin
                if (countdown_reg > TIMER_WIDTH'(1))
                begin
                    countdown_next = countdown_reg - TIMER_WIDTH'(1);
                end
                else if (active)
                begin
                    countdown_next = pulse_load;
                end
                else
                begin
                    phase_next     = rfi_pkg::PH_IDLE;
                    countdown_next = '0;
                    ev             = rfi_pkg::EV_END;
                    if (cfg.lockout_enable)
                    begin
                        lockout_next = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next     = rfi_pkg::PH_IDLE;
                countdown_next = '0;
            end
        endcase
    end

    // Edge memory and the saturating uptime counter.
    assign prev_active_next = active;
    assign uptime_next      = (uptime_reg < arm) ? uptime_reg + TIMER_WIDTH'(1) : uptime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_active_reg <= 1'b0;
            phase_reg       <= rfi_pkg::PH_IDLE;
            countdown_reg   <= '0;
            uptime_reg      <= '0;
            lockout_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            prev_active_reg <= prev_active_next;
            phase_reg       <= phase_next;
            countdown_reg   <= countdown_next;
            uptime_reg      <= uptime_next;
            lockout_reg     <= lockout_next;
        end
    end

    // Result word reflects the state after this tick.
    assign res.fire_enable = (phase_next == rfi_pkg::PH_FIRE);
    assign res.phase       = phase_next;
    assign res.locked_out  = lockout_next;
    assign res.event_res   = ev;

    // Lockout is only cleared by reset.
    `ASSERT_NEXT(a_lockout_sticky, clk, rst_n, lockout_reg, lockout_reg)
    // A debounce wait always has ticks left to count.
    `ASSERT_SAME(a_wait_nonzero, clk, rst_n, phase_reg == rfi_pkg::PH_WAIT, countdown_reg != '0)
    // A fire start leaves the sequencer firing with a loaded period.
    `ASSERT_NEXT(a_start_fires, clk, rst_n, step_en && (ev == rfi_pkg::EV_START), (phase_reg == rfi_pkg::PH_FIRE) && (countdown_reg != '0))

endmodule

// ===== hdl/release_fire_interlock.sv =====
// An input register and a result register bracket the combinational sequencer update.
// One tick word per cycle while the result register drains. While a result word waits,
// one more word is taken into the input register and further words are held off until
// the result drains.
// Reset (rst_n, asynchronous, active low) sets registers to defaults, the sequencer to idle,
// the uptime counter to zero and clears lockout; no clearing pass is needed.
`include "assert_macros.svh"

module release_fire_interlock #(
    parameter int TIMER_WIDTH  = 16,
    parameter int NUM_INHIBITS = 3
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    rfi_item_if.sink                       item,
    rfi_result_if.source                   result,
    input  logic                           cfg_wr_en,
    input  logic [rfi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    rfi_pkg::cfg_t      cfg;
    rfi_pkg::in_word_t  s1_word_reg;
    rfi_pkg::out_word_t out_word_reg;
    rfi_pkg::out_word_t core_res;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;

    rfi_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rfi_core #(
        .TIMER_WIDTH  (TIMER_WIDTH),
        .NUM_INHIBITS (NUM_INHIBITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (out_load),
        .word    (s1_word_reg),
        .res     (core_res)
    );

    // Pipeline flow: a stored word moves on when the result register is free or draining.
    assign out_load       = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready     = !s1_valid_reg || out_load;
    assign s1_valid_next  = item.ready ? item.valid : s1_valid_reg;
    assign out_valid_next = out_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input word register.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_word_reg.release_level  <= item.release_level;
            s1_word_reg.inhibit_levels <= item.inhibit_levels;
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= core_res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.fire_enable = out_word_reg.fire_enable;
    assign result.phase       = out_word_reg.phase;
    assign result.locked_out  = out_word_reg.locked_out;
    assign result.event_res   = out_word_reg.event_res;

    // Loading a word into the result register raises the result valid flag.
    `ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, out_valid_reg)

endmodule
